// ----- rtl/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned ENTRY_W    = 2 * OFF_W;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  // table read address source
  typedef enum logic [1:0] {
    RD_IDX,
    RD_PTR_DN,
    RD_PTR_UP
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    logic    init_walk;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    inc_idx;
    logic    step_prev;
    logic    ptr_from_count;
    logic    ptr_from_idx;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    wr_shift;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    load_res;
    status_e res_status;
    logic    res_off;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic reject;
    logic free_bad;
    logic idx_at_end;
    logic fit;
    logic match;
    logic ptr_eq_idx;
    logic ptr_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ffha_dp.sv -----
// Datapath: request latches, block table, walk/shift pointers, result register.
`default_nettype none

module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffha_pkg::cmd_t                cmd_i,
  output      ffha_pkg::sts_t                sts_o,
  input  wire logic                          req_kind_i,
  input  wire logic [ffha_pkg::SIZE_W-1:0]   req_size_i,
  input  wire logic [ffha_pkg::OFF_W-1:0]    req_off_i,
  input  wire logic                          m_tready_i,
  output      logic                          m_tvalid_o,
  output      logic [ffha_pkg::OFF_W-1:0]    m_off_o,
  output      logic [ffha_pkg::STAT_W-1:0]   m_status_o
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OW = ffha_pkg::OFF_W;
  localparam int unsigned EW = ffha_pkg::ENTRY_W;

  localparam logic [OW-1:0] FOOT     = OW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [OW-1:0] HDR16    = OW'(HEADER_BYTES);
  localparam logic [OW+1:0] HDR18    = (OW+2)'(HEADER_BYTES);
  localparam logic [OW:0]   FREE_LO  = (OW+1)'(2 * HEADER_BYTES);
  localparam logic [OW:0]   FREE_HI  = (OW+1)'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);

  // request
  logic          kind_q;
  logic          big_q;
  logic [OW-1:0] size_lo_q;
  logic [OW-1:0] off_q;

  // walk state
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [OW+1:0] prev_end_q, prev_end_d;

  // result
  logic          out_valid_q;
  logic [OW-1:0] out_off_q;
  logic [ffha_pkg::STAT_W-1:0] out_status_q;

  // table
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [OW-1:0] rd_start;
  logic [OW-1:0] rd_len;

  logic [CW-1:0] ptr_dn;
  logic [CW-1:0] ptr_up;
  logic [OW+1:0] next_hdr;
  logic [OW+1:0] gap;
  logic [OW+1:0] need;
  logic [OW-1:0] hdr_addr;

  assign rd_start = rd_data[OW-1:0];
  assign rd_len   = rd_data[EW-1:OW];
  assign ptr_dn   = ptr_q - 1'b1;
  assign ptr_up   = ptr_q + 1'b1;
  assign hdr_addr = off_q - HDR16;

  always_comb begin
    unique case (cmd_i.rd_sel)
      ffha_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
      ffha_pkg::RD_PTR_DN: rd_addr = ptr_dn[AW-1:0];
      ffha_pkg::RD_PTR_UP: rd_addr = ptr_up[AW-1:0];
      default:             rd_addr = idx_q[AW-1:0];
    endcase
  end

  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_new;
  assign wr_addr = cmd_i.wr_new ? idx_q[AW-1:0] : ptr_q[AW-1:0];
  assign wr_data = cmd_i.wr_new ? {size_lo_q, prev_end_q[OW-1:0]} : rd_data;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // gap test against the next header (foot sentinel past the last block)
  always_comb begin
    next_hdr = sts_o.idx_at_end ? {2'b00, FOOT} : {2'b00, rd_start};
    gap      = next_hdr - prev_end_q;
    need     = HDR18 + {2'b00, size_lo_q};
  end

  always_comb begin
    sts_o.is_free    = (kind_q == ffha_pkg::KIND_FREE);
    sts_o.reject     = big_q | (count_q >= CNT_MAX);
    sts_o.free_bad   = ({1'b0, off_q} < FREE_LO) | ({1'b0, off_q} >= FREE_HI);
    sts_o.idx_at_end = (idx_q == count_q);
    sts_o.fit        = ~big_q & (next_hdr >= prev_end_q) & (gap >= need);
    sts_o.match      = (rd_start == hdr_addr);
    sts_o.ptr_eq_idx = (ptr_q == idx_q);
    sts_o.ptr_last   = (ptr_up == count_q);
    sts_o.out_busy   = out_valid_q & ~m_tready_i;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end

    idx_d = idx_q;
    if (cmd_i.init_walk) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + 1'b1;
    end

    ptr_d = ptr_q;
    priority if (cmd_i.ptr_from_count) begin
      ptr_d = count_q;
    end else if (cmd_i.ptr_from_idx) begin
      ptr_d = idx_q;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_dn;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_up;
    end

    prev_end_d = prev_end_q;
    if (cmd_i.init_walk) begin
      prev_end_d = HDR18;
    end else if (cmd_i.step_prev) begin
      prev_end_d = {2'b00, rd_start} + HDR18 + {2'b00, rd_len};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_end_q <= prev_end_d;
    if (cmd_i.latch) begin
      kind_q    <= req_kind_i;
      big_q     <= |req_size_i[ffha_pkg::SIZE_W-1:OW];
      size_lo_q <= req_size_i[OW-1:0];
      off_q     <= req_off_i;
    end
    if (cmd_i.load_res) begin
      out_status_q <= cmd_i.res_status;
      out_off_q    <= cmd_i.res_off ? (prev_end_q[OW-1:0] + HDR16) : '0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_off_o    = out_off_q;
  assign m_status_o = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/ffha_ctrl.sv -----
// Controller: sequences table walk, shift and result for each request.
`default_nettype none

module ffha_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  output      logic           s_tready_o,
  input  wire ffha_pkg::sts_t sts_i,
  output      ffha_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    IDLE,
    DECIDE,
    WALK_RD,
    WALK_CHK,
    ASH_CHK,
    ASH_WR,
    INSERT,
    FSH_CHK,
    FSH_WR,
    RESP
  } state_e;

  state_e            state_q, state_d;
  ffha_pkg::status_e res_status_q, res_status_d;
  logic              res_off_q, res_off_d;
  logic              res_set;

  assign s_tready_o = (state_q == IDLE);

  always_comb begin
    state_d      = state_q;
    res_set      = 1'b0;
    res_status_d = ffha_pkg::ST_OK;
    res_off_d    = 1'b0;
    cmd_o        = '0;
    cmd_o.rd_sel = ffha_pkg::RD_IDX;
    cmd_o.res_status = res_status_q;
    cmd_o.res_off    = res_off_q;

    unique case (state_q)
      IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = DECIDE;
        end
      end
      DECIDE: begin
        cmd_o.init_walk = 1'b1;
        if (sts_i.is_free ? sts_i.free_bad : sts_i.reject) begin
          res_set      = 1'b1;
          res_status_d = sts_i.is_free ? ffha_pkg::ST_BAD_FREE : ffha_pkg::ST_NO_SPACE;
          state_d      = RESP;
        end else begin
          state_d = WALK_RD;
        end
      end
      WALK_RD: begin
        if (sts_i.is_free && sts_i.idx_at_end) begin
          res_set      = 1'b1;
          res_status_d = ffha_pkg::ST_BAD_FREE;
          state_d      = RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = WALK_CHK;
        end
      end
      WALK_CHK: begin
        if (sts_i.is_free) begin
          if (sts_i.match) begin
            cmd_o.ptr_from_idx = 1'b1;
            state_d            = FSH_CHK;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d       = WALK_RD;
          end
        end else if (sts_i.fit) begin
          cmd_o.ptr_from_count = 1'b1;
          state_d              = ASH_CHK;
        end else if (sts_i.idx_at_end) begin
          res_set      = 1'b1;
          res_status_d = ffha_pkg::ST_NO_SPACE;
          state_d      = RESP;
        end else begin
          cmd_o.step_prev = 1'b1;
          cmd_o.inc_idx   = 1'b1;
          state_d         = WALK_RD;
        end
      end
      ASH_CHK: begin
        if (sts_i.ptr_eq_idx) begin
          state_d = INSERT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ffha_pkg::RD_PTR_DN;
          state_d      = ASH_WR;
        end
      end
      ASH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = ASH_CHK;
      end
      INSERT: begin
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        res_set       = 1'b1;
        res_status_d  = ffha_pkg::ST_OK;
        res_off_d     = 1'b1;
        state_d       = RESP;
      end
      FSH_CHK: begin
        if (sts_i.ptr_last) begin
          cmd_o.cnt_dec = 1'b1;
          res_set       = 1'b1;
          res_status_d  = ffha_pkg::ST_OK;
          state_d       = RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ffha_pkg::RD_PTR_UP;
          state_d      = FSH_WR;
        end
      end
      FSH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = FSH_CHK;
      end
      RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_res = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      res_status_q <= ffha_pkg::ST_OK;
      res_off_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_set) begin
        res_status_q <= res_status_d;
        res_off_q    <= res_off_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level: first-fit heap allocator with an address-ordered block table.
// Sequencing per request: an allocate walks the table to the first fitting gap, moves
//   the later entries up one place and writes the new block; a free walks to the matching
//   entry and moves the later entries down; a rejected request goes straight to the result.
// Throughput: one request at a time; the next transfer can be taken in the cycle after the
//   result loads. Reset: asynchronous, active low; table empty.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // request channel
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [ffha_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // request_size[31:0], free_offset[47:32]
  input  wire logic                               s_axis_tuser,  // kind: 0 allocate, 1 free
  // result channel
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output      logic [ffha_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // payload_offset[15:0], status[17:16], zero pad
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  logic [ffha_pkg::OFF_W-1:0]  res_off;
  logic [ffha_pkg::STAT_W-1:0] res_status;

  // Controller only accepts a transfer when idle; a waiting result sits in the
  // datapath output register and does not hold off the next request.
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_kind_i (s_axis_tuser),
    .req_size_i (s_axis_tdata[31:0]),
    .req_off_i  (s_axis_tdata[47:32]),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_off_o    (res_off),
    .m_status_o (res_status)
  );

  assign m_axis_tdata = {6'b000000, res_status, res_off};

endmodule

`default_nettype wire
